FILE: hdl/bps_pkg.sv
// Shared types, register indexes and helpers for the byte pattern search block.
// No dependencies; every other file takes names from here by scope.
package bps_pkg;

   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 64;
   localparam int PATTERN_REG_BYTES = 16;
   localparam int PATTERN_REG_W     = 8 * PATTERN_REG_BYTES;
   localparam int LENGTH_W          = 5;
   localparam int RANGE_W           = 24;
   localparam int START_W           = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CASE_FOLD    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_FIRST  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LAST   = 3'd5;

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

   typedef struct packed {
      logic [PATTERN_REG_W-1:0] pattern;
      logic                     fold;
   } cmp_cfg_type;

   typedef struct packed {
      logic               match_found;
      logic [START_W-1:0] match_start;
      logic               search_done;
   } rsp_word_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
      logic [7:0] r;
      r = b;
      if (fold && (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z)) begin
         r = b + ASCII_CASE_OFS;
      end
      return r;
   endfunction

endpackage

FILE: hdl/bps_match.sv
// Parallel compare of the byte window against the configured pattern.
// Depends on bps_pkg for the compare config struct and the case fold helper.
module bps_match #(
   parameter int PATTERN_MAX = 16,
   parameter int LEN_W       = 5
) (
   input  logic [PATTERN_MAX-1:0][7:0] win,
   input  bps_pkg::cmp_cfg_type        cfg,
   input  logic [LEN_W-1:0]            len,
   output logic                        all_equal
);

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic [PATTERN_MAX-1:0] eq;

   genvar k;
   generate
      for (k = 0; k < PATTERN_MAX; k++) begin : g_byte
         logic [7:0]       pat;
         logic [LEN_W-1:0] lag;
         logic [7:0]       sel;
         logic             unused;

         if (k < bps_pkg::PATTERN_REG_BYTES) begin : g_reg
            assign pat = cfg.pattern[8*k +: 8];
         end else begin : g_zero
            assign pat = 8'h00;
         end

         // pattern byte k lines up with the window byte len-1-k back
         assign unused = (LEN_W'(k) >= len);
         assign lag    = len - LEN_W'(1) - LEN_W'(k);

         always_comb begin
            sel = 8'h00;
            if (!unused) begin
               sel = win[lag[IDX_W-1:0]];
            end
         end

         assign eq[k] = unused ||
            (bps_pkg::fold_byte(sel, cfg.fold) == bps_pkg::fold_byte(pat, cfg.fold));
      end
   endgenerate

   assign all_equal = &eq;

endmodule

FILE: hdl/byte_pattern_search_top.sv
// Top level of the byte pattern search: config registers, window, position, result buffer.
// Depends on bps_pkg and bps_match.
//
//   channel  | ports                               | direction | handshake
//   req      | req_data_byte, req_last_byte        | in        | req_valid / req_stall
//   rsp      | rsp_match_found, _start, _done      | out       | rsp_valid / rsp_stall
//   csr      | csr_index, csr_write_data           | in        | csr_write_enable
//
// One byte per cycle while req_stall is low: each accepted word is compared combinationally
// and its result is registered in the output register, or in the skid entry if that is stalled.
// The result side has an output register plus one skid entry; req_stall rises only
// when both hold words, and is a plain register output.
// Synchronous reset clears the window, position, found flag and both buffer valid flags.
// The word flagged last returns the window, position and found flag to their reset values.
module byte_pattern_search_top #(
   parameter int PATTERN_MAX = 16,
   parameter int ADDR_BITS   = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_match_found,
   output logic [bps_pkg::START_W-1:0]        rsp_match_start,
   output logic                               rsp_search_done,
   input  logic                               csr_write_enable,
   input  logic [bps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bps_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int LEN_W = ($clog2(PATTERN_MAX + 1) > bps_pkg::LENGTH_W) ?
                          $clog2(PATTERN_MAX + 1) : bps_pkg::LENGTH_W;
   localparam int CW    = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;
   localparam int RW    = (CW > bps_pkg::RANGE_W) ? CW : bps_pkg::RANGE_W;

   // configuration registers
   logic [bps_pkg::CSR_DATA_W-1:0] pattern_low_ff, pattern_high_ff;
   logic [bps_pkg::LENGTH_W-1:0]   pattern_length_ff;
   logic                           case_fold_ff;
   logic [bps_pkg::RANGE_W-1:0]    range_first_ff, range_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= bps_pkg::LENGTH_W'(1);
         case_fold_ff      <= 1'b0;
         range_first_ff    <= '0;
         range_last_ff     <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bps_pkg::CSR_PATTERN_LOW:  pattern_low_ff    <= csr_write_data;
            bps_pkg::CSR_PATTERN_HIGH: pattern_high_ff   <= csr_write_data;
            bps_pkg::CSR_LENGTH:       pattern_length_ff <= csr_write_data[bps_pkg::LENGTH_W-1:0];
            bps_pkg::CSR_CASE_FOLD:    case_fold_ff      <= csr_write_data[0];
            bps_pkg::CSR_RANGE_FIRST:  range_first_ff    <= csr_write_data[bps_pkg::RANGE_W-1:0];
            bps_pkg::CSR_RANGE_LAST:   range_last_ff     <= csr_write_data[bps_pkg::RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   // search state
   logic [PATTERN_MAX-1:0][7:0] win_ff, win_in, win_shift;
   logic [ADDR_BITS-1:0]        pos_ff, pos_in;
   logic                        found_ff, found_in;

   logic accept;
   assign accept = req_valid && !req_stall;

   generate
      if (PATTERN_MAX > 1) begin : g_shift
         assign win_shift = {win_ff[PATTERN_MAX-2:0], req_data_byte};
      end else begin : g_single
         assign win_shift = req_data_byte;
      end
   endgenerate

   logic [LEN_W-1:0] len_eff;
   assign len_eff = (LEN_W'(pattern_length_ff) > LEN_W'(PATTERN_MAX)) ?
                    LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length_ff);

   bps_pkg::cmp_cfg_type cmp_cfg;
   assign cmp_cfg.pattern = {pattern_high_ff, pattern_low_ff};
   assign cmp_cfg.fold    = case_fold_ff;

   logic all_equal;

   bps_match #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W)
   ) u_match (
      .win       (win_shift),
      .cfg       (cmp_cfg),
      .len       (len_eff),
      .all_equal (all_equal)
   );

   logic [CW-1:0]        pos_p1, start_w;
   logic [RW-1:0]        start_r;
   logic                 enough, in_range, hit;

   assign pos_p1   = CW'(pos_ff) + CW'(1);
   assign enough   = (len_eff != '0) && (pos_p1 >= CW'(len_eff));
   assign start_w  = pos_p1 - CW'(len_eff);
   // keep the carry: a start one past the top address never lies in range
   assign start_r  = RW'(start_w);
   assign in_range = (start_r >= RW'(range_first_ff)) && (start_r <= RW'(range_last_ff));
   assign hit      = !found_ff && enough && in_range && all_equal;

   bps_pkg::rsp_word_type new_word;
   assign new_word.match_found = hit;
   assign new_word.match_start = hit ? start_r[bps_pkg::START_W-1:0] : '0;
   assign new_word.search_done = req_last_byte || found_ff || hit;

   always_comb begin
      win_in   = win_ff;
      pos_in   = pos_ff;
      found_in = found_ff;
      if (accept) begin
         if (req_last_byte) begin
            win_in   = '0;
            pos_in   = '0;
            found_in = 1'b0;
         end else begin
            win_in   = win_shift;
            pos_in   = pos_ff + ADDR_BITS'(1);
            found_in = found_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         pos_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
   end

   // result buffer: output register plus one skid entry
   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   bps_pkg::rsp_word_type out_ff, out_in, skid_ff, skid_in;
   logic                  take;

   assign take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            // drain the skid word first; no word is accepted while it is full
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_in       = new_word;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_match_found = out_ff.match_found;
   assign rsp_match_start = out_ff.match_start;
   assign rsp_search_done = out_ff.search_done;

endmodule

FILE: hdl/bps_checker.sv
// Port-level checks for byte_pattern_search_top, bound onto every instance.
// Depends on bps_pkg for field widths.
module bps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_match_found,
   input logic [bps_pkg::START_W-1:0]     rsp_match_start,
   input logic                            rsp_search_done
);

   // a reported match always closes the search
   a_found_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_found |-> rsp_search_done)
      else $error("match reported without search_done");

   // start address is zero on words without a match
   a_start_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_match_start == '0)
      else $error("nonzero match_start without a match");

   // reset empties the result buffer
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result buffer not empty after reset");

   // stalled result word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_match_found) &&
         $stable(rsp_match_start) && $stable(rsp_search_done))
      else $error("stalled result word changed");

   // an accepted word always leaves a result word waiting
   a_accept_rsp : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no result word");

endmodule

bind byte_pattern_search_top bps_checker u_bps_checker (.*);

FILE: tb/byte_pattern_search_checker.sv
`timescale 1ns / 1ps
// Result checker for byte_pattern_search_top: follows register writes, predicts each result word
// from the accepted request words and compares it field by field. Depends on bps_pkg.
module byte_pattern_search_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_match_found,
   input  logic [bps_pkg::START_W-1:0]     rsp_match_start,
   input  logic                            rsp_search_done,
   input  logic                            csr_write_enable,
   input  logic [bps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bps_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                              error_count,
   output int                              outstanding,
   output int                              match_count
);

   localparam int WINDOW = 16;

   // shadow of the register file
   logic [63:0]                   pat_low;
   logic [63:0]                   pat_high;
   logic [bps_pkg::LENGTH_W-1:0]  pat_len;
   logic                          fold_on;
   logic [bps_pkg::RANGE_W-1:0]   first_addr;
   logic [bps_pkg::RANGE_W-1:0]   last_addr;

   // scan state
   logic [7:0]                    history [WINDOW];
   logic [bps_pkg::START_W-1:0]   next_addr;
   logic                          found_flag;

   bps_pkg::rsp_word_type         expected_words [$];

   function automatic logic [7:0] lower_case(input logic [7:0] b);
      if (fold_on && b >= bps_pkg::ASCII_UPPER_A && b <= bps_pkg::ASCII_UPPER_Z) begin
         return b + bps_pkg::ASCII_CASE_OFS;
      end
      return b;
   endfunction

   function automatic void clear_scan();
      foreach (history[i]) history[i] = 8'h00;
      next_addr = '0;
      found_flag = 1'b0;
   endfunction

   // Advance the scan by one buffer byte and return the result word it produces.
   function automatic bps_pkg::rsp_word_type scan_byte(input logic [7:0] b, input logic fin);
      bps_pkg::rsp_word_type w;
      int unsigned    span;
      int unsigned    start_addr;
      int unsigned    k;
      logic [127:0]   pattern;
      logic           same;
      pattern = {pat_high, pat_low};
      for (k = WINDOW - 1; k > 0; k--) history[k] = history[k - 1];
      history[0] = b;
      span = (pat_len > WINDOW) ? WINDOW : pat_len;
      w = '0;
      if (!found_flag && span != 0 && int'(next_addr) + 1 >= span) begin
         start_addr = int'(next_addr) + 1 - span;
         if (start_addr >= first_addr && start_addr <= last_addr) begin
            same = 1'b1;
            for (k = 0; k < span; k++) begin
               if (lower_case(history[span - 1 - k]) != lower_case(pattern[8*k +: 8])) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               w.match_found = 1'b1;
               w.match_start = start_addr[bps_pkg::START_W-1:0];
               found_flag = 1'b1;
            end
         end
      end
      w.search_done = fin || found_flag;
      if (fin) begin
         clear_scan();
      end else begin
         next_addr = next_addr + 1'b1;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      bps_pkg::rsp_word_type want;
      if (reset) begin
         pat_low = '0;
         pat_high = '0;
         pat_len = bps_pkg::LENGTH_W'(1);
         fold_on = 1'b0;
         first_addr = '0;
         last_addr = '1;
         clear_scan();
         expected_words.delete();
         error_count = 0;
         match_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               bps_pkg::CSR_PATTERN_LOW:  pat_low = csr_write_data;
               bps_pkg::CSR_PATTERN_HIGH: pat_high = csr_write_data;
               bps_pkg::CSR_LENGTH:       pat_len = csr_write_data[bps_pkg::LENGTH_W-1:0];
               bps_pkg::CSR_CASE_FOLD:    fold_on = csr_write_data[0];
               bps_pkg::CSR_RANGE_FIRST:  first_addr = csr_write_data[bps_pkg::RANGE_W-1:0];
               bps_pkg::CSR_RANGE_LAST:   last_addr = csr_write_data[bps_pkg::RANGE_W-1:0];
               default: ; // drop writes to unmapped indexes
            endcase
         end
         // retire the older word before queuing the new one
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result word found=%0b start=%h done=%0b", $time,
                        rsp_match_found, rsp_match_start, rsp_search_done);
            end else begin
               want = expected_words.pop_front();
               if (rsp_match_found) match_count++;
               if (rsp_match_found !== want.match_found) begin
                  error_count++;
                  $display("%0t: match_found expected %0b actual %0b", $time,
                           want.match_found, rsp_match_found);
               end
               if (rsp_match_start !== want.match_start) begin
                  error_count++;
                  $display("%0t: match_start expected %h actual %h", $time,
                           want.match_start, rsp_match_start);
               end
               if (rsp_search_done !== want.search_done) begin
                  error_count++;
                  $display("%0t: search_done expected %0b actual %0b", $time,
                           want.search_done, rsp_search_done);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(scan_byte(req_data_byte, req_last_byte));
         end
      end
      outstanding <= expected_words.size();
   end

endmodule

FILE: tb/byte_pattern_search_top_test.sv
`timescale 1ns / 1ps
// Testbench top for byte_pattern_search_top: drives buffers and register settings, idles both
// sides at random and gives the verdict. Depends on bps_pkg and byte_pattern_search_checker.
module byte_pattern_search_top_test;

   localparam int ACTIVITY_LIMIT = 2000;
   localparam int ITEM_GOAL      = 550;
   localparam int SETTLE_CYCLES  = 3;
   localparam int LONG_HOLD      = 100;
   localparam logic [bps_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [bps_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct {
      logic [63:0]                  low;
      logic [63:0]                  high;
      logic [bps_pkg::LENGTH_W-1:0] len;
      logic                         fold;
      logic [bps_pkg::RANGE_W-1:0]  first;
      logic [bps_pkg::RANGE_W-1:0]  last;
   } search_setting_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [7:0]                      req_data_byte = 8'h00;
   logic                            req_last_byte = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_match_found;
   logic [bps_pkg::START_W-1:0]     rsp_match_start;
   logic                            rsp_search_done;
   logic                            csr_write_enable = 1'b0;
   logic [bps_pkg::CSR_INDEX_W-1:0] csr_index = bps_pkg::CSR_PATTERN_LOW;
   logic [bps_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   int                     error_count;
   int                     outstanding;
   int                     match_count;
   int                     idle_cycles = 0;
   int                     bytes_sent = 0;
   int                     buffers_sent = 0;
   int                     settings_used = 0;
   bit                     req_gaps_on = 1'b0;
   bit                     rsp_gaps_on = 1'b0;
   bit                     long_hold_req = 1'b0;
   search_setting_type     active;

   byte_pattern_search_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_start  (rsp_match_start),
      .rsp_search_done  (rsp_search_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   byte_pattern_search_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_start  (rsp_match_start),
      .rsp_search_done  (rsp_search_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .outstanding      (outstanding),
      .match_count      (match_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
   endfunction

   function automatic search_setting_type setting_of(input logic [63:0] low,
                                                     input logic [63:0] high,
                                                     input logic [bps_pkg::LENGTH_W-1:0] len,
                                                     input logic fold,
                                                     input logic [bps_pkg::RANGE_W-1:0] first,
                                                     input logic [bps_pkg::RANGE_W-1:0] last);
      search_setting_type s;
      s.low = low;
      s.high = high;
      s.len = len;
      s.fold = fold;
      s.first = first;
      s.last = last;
      return s;
   endfunction

   // result side: random holds, plus one long hold on request
   initial begin : rsp_side
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            if (long_hold_req) begin
               long_hold_req = 1'b0;
               hold = LONG_HOLD;
            end else if (rsp_gaps_on && $urandom_range(99) < 25) begin
               hold = idle_length();
            end
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= ACTIVITY_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one word and return in the time step of the edge that takes it.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = (req_gaps_on && $urandom_range(99) < 30) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input search_setting_type s);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      active = s;
      settings_used++;
      csr_write_enable <= 1'b1;
      csr_index <= bps_pkg::CSR_PATTERN_LOW;
      csr_write_data <= s.low;
      @(posedge clock);
      csr_index <= bps_pkg::CSR_PATTERN_HIGH;
      csr_write_data <= s.high;
      @(posedge clock);
      // unused upper bits carry garbage
      csr_index <= bps_pkg::CSR_LENGTH;
      csr_write_data <= {junk[63:bps_pkg::LENGTH_W], s.len};
      @(posedge clock);
      csr_index <= bps_pkg::CSR_CASE_FOLD;
      csr_write_data <= {junk[63:1], s.fold};
      @(posedge clock);
      csr_index <= bps_pkg::CSR_RANGE_FIRST;
      csr_write_data <= {junk[63:bps_pkg::RANGE_W], s.first};
      @(posedge clock);
      csr_index <= bps_pkg::CSR_RANGE_LAST;
      csr_write_data <= {junk[bps_pkg::RANGE_W-1:0], junk[63-bps_pkg::RANGE_W:bps_pkg::RANGE_W],
                         s.last};
      @(posedge clock);
      csr_index <= ($urandom_range(1) != 0) ? CSR_SPARE_A : CSR_SPARE_B;
      csr_write_data <= ~junk;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One buffer: noise, or the pattern planted once or twice (maybe with one bit flipped).
   task automatic send_buffer();
      logic [7:0]   stream_q [$];
      logic [127:0] pat;
      logic [7:0]   b;
      int           span;
      int           kind;
      int           copies;
      int           lead;
      int           flip_at;
      int           k;
      pat = {active.high, active.low};
      span = (active.len > 16) ? 16 : active.len;
      kind = $urandom_range(9);
      if (kind < 2) begin
         repeat ($urandom_range(20, 1)) stream_q.push_back(8'($urandom_range(255)));
      end else begin
         copies = (kind == 3) ? 2 : 1;
         flip_at = (kind == 2 && span > 0) ? $urandom_range(span - 1) : -1;
         repeat (copies) begin
            lead = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(8);
            repeat (lead) begin
               // pattern bytes in the lead-in set up partial matches
               k = $urandom_range(15);
               b = ($urandom_range(1) != 0) ? pat[8*k +: 8] : 8'($urandom_range(255));
               stream_q.push_back(b);
            end
            for (k = 0; k < span; k++) begin
               b = pat[8*k +: 8];
               if (active.fold && $urandom_range(1) != 0) begin
                  if (b >= bps_pkg::ASCII_UPPER_A && b <= bps_pkg::ASCII_UPPER_Z) begin
                     b = b + bps_pkg::ASCII_CASE_OFS;
                  end else if (b >= bps_pkg::ASCII_UPPER_A + bps_pkg::ASCII_CASE_OFS &&
                               b <= bps_pkg::ASCII_UPPER_Z + bps_pkg::ASCII_CASE_OFS) begin
                     b = b - bps_pkg::ASCII_CASE_OFS;
                  end
               end
               if (k == flip_at) b = b ^ 8'(1 << $urandom_range(7));
               stream_q.push_back(b);
            end
         end
         // no tail at all puts the match on the final byte
         if ($urandom_range(2) != 0) begin
            repeat ($urandom_range(6)) stream_q.push_back(8'($urandom_range(255)));
         end
      end
      if (stream_q.size() == 0) stream_q.push_back(8'($urandom_range(255)));
      foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
      buffers_sent++;
   endtask

   initial begin : stimulus
      search_setting_type s;
      logic [127:0]    pat;
      logic [7:0]      ch;
      int              phase;
      int              pick;
      int              k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      active = setting_of('0, '0, bps_pkg::LENGTH_W'(1), 1'b0, '0, '1);
      @(posedge clock);

      // power-up registers: one zero byte, any start
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      drain();
      // "aBc" with folding; the match ends on the final byte
      apply_setting(setting_of(64'h0000_0000_0063_4261, '0, bps_pkg::LENGTH_W'(3), 1'b1,
                               '0, '1));
      send_byte(8'h78, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h43, 1'b1);
      drain();
      // zero length never matches
      apply_setting(setting_of('0, '0, bps_pkg::LENGTH_W'(0), 1'b0, '0, '1));
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      drain();
      // reversed range allows nothing
      apply_setting(setting_of('0, '0, bps_pkg::LENGTH_W'(1), 1'b0,
                               bps_pkg::RANGE_W'(1), bps_pkg::RANGE_W'(0)));
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      drain();
      // oversized length acts as 16; the zeroed window must not match early
      apply_setting(setting_of('0, '0, bps_pkg::LENGTH_W'(31), 1'b0, '0, '1));
      repeat (15) send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);

      phase = 0;
      while (bytes_sent < ITEM_GOAL) begin
         drain();
         for (k = 0; k < 16; k++) begin
            if ($urandom_range(99) < 40) begin
               // letters plus their non-letter neighbors
               ch = 8'($urandom_range(bps_pkg::ASCII_UPPER_Z + 1, bps_pkg::ASCII_UPPER_A - 1));
               if ($urandom_range(1) != 0) ch = ch + bps_pkg::ASCII_CASE_OFS;
            end else begin
               ch = 8'($urandom_range(255));
            end
            pat[8*k +: 8] = ch;
         end
         s.low = pat[63:0];
         s.high = pat[127:64];
         pick = $urandom_range(9);
         case (pick)
            0:          s.len = bps_pkg::LENGTH_W'(($urandom_range(1) != 0) ? 0 :
                                                   $urandom_range(31, 17));
            1, 2, 3, 4: s.len = bps_pkg::LENGTH_W'($urandom_range(4, 1));
            5, 6, 7:    s.len = bps_pkg::LENGTH_W'($urandom_range(16, 5));
            8:          s.len = bps_pkg::LENGTH_W'(16);
            default:    s.len = bps_pkg::LENGTH_W'(1);
         endcase
         s.fold = 1'($urandom_range(1));
         pick = $urandom_range(5);
         case (pick)
            2: begin
               s.first = bps_pkg::RANGE_W'($urandom_range(20));
               s.last = s.first + bps_pkg::RANGE_W'($urandom_range(15));
            end
            3: begin
               s.first = bps_pkg::RANGE_W'($urandom_range(30, 1));
               s.last = bps_pkg::RANGE_W'($urandom_range(s.first - 1));
            end
            4: begin
               s.first = '0;
               s.last = bps_pkg::RANGE_W'($urandom_range(10));
            end
            5: begin
               s.first = ($urandom_range(3) == 0) ? {bps_pkg::RANGE_W{1'b1}} :
                         bps_pkg::RANGE_W'($urandom_range(24'hFFFFFF, 24'h1000));
               s.last = '1;
            end
            default: begin
               s.first = '0;
               s.last = '1;
            end
         endcase
         apply_setting(s);
         req_gaps_on = (phase % 4 == 0) || (phase % 4 == 2);
         rsp_gaps_on = (phase % 4 < 2);
         if (phase == 2) begin
            // keep offering while results back up
            req_gaps_on = 1'b0;
            long_hold_req = 1'b1;
         end
         repeat ($urandom_range(6, 3)) send_buffer();
         phase++;
      end
      drain();

      $display("Run: %0d bytes in %0d buffers under %0d register settings, %0d matches seen.",
               bytes_sent, buffers_sent, settings_used, match_count);
      $display("Covered case folding, lengths 0 to 31, odd ranges, result backpressure.");
      if (error_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
